>>> sv/prime_factorizer_core_macros.svh
`ifndef PRIME_FACTORIZER_CORE_MACROS_SVH
`define PRIME_FACTORIZER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pf assertion failed");

// next-cycle implication, checked outside reset
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pf assertion failed");

`endif

>>> sv/pf_pkg.sv
package pf_pkg;

    localparam int VALUE_WIDTH = 31;

endpackage

>>> sv/pf_div.sv
module pf_div #(
    parameter int W = pf_pkg::VALUE_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W:0]    r_p,    n_p;
    logic [W-1:0]  r_q,    n_q;

    logic [W:0] w_shift;
    logic [W:0] w_diff;

    // restoring step, one quotient bit a cycle
    assign w_shift = {r_p[W-1:0], r_q[W-1]};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_p    = r_p;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_p    = '0;
            n_q    = i_dividend;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, i_divisor}) begin
                n_p = w_diff;
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_p = w_shift;
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_p <= n_p;
        r_q <= n_q;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_p[W-1:0];

endmodule

>>> sv/prime_factorizer_core.sv
// channel  | ports                        | handshake
// ---------+------------------------------+-------------------------------
// input    | i_value                      | start high while busy low
// result   | o_factor, o_last             | o_valid high for one cycle
//
// each trial division runs in the single bit-serial divider
// an item takes about one trial division per divisor up to sqrt, plus one per factor
// inputs 0 and 1 give their result the cycle after acceptance, busy stays low
// reset is synchronous, active low, and clears the sequencer and divider control
// results cannot be stalled; busy holds off new words until the last factor
`include "prime_factorizer_core_macros.svh"

module prime_factorizer_core #(
    parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_factor,
    output logic                   o_last
);

    localparam int W = VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    t_state       r_state, n_state;
    logic [W-1:0] r_rem,   n_rem;
    logic [W-1:0] r_d,     n_d;
    logic [W:0]   r_sq,    n_sq;
    logic         r_valid, n_valid;
    logic [W-1:0] r_factor, n_factor;
    logic         r_last,  n_last;

    logic         w_accept;
    logic         w_sq_over;
    logic         w_div_start;
    logic         w_div_done;
    logic [W-1:0] w_quo;
    logic [W-1:0] w_div_rem;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_sq_over = (r_sq > {1'b0, r_rem});
    assign w_div_start = (r_state == S_CHECK) && !w_sq_over;

    pf_div #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_div_rem)
    );

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_d      = r_d;
        n_sq     = r_sq;
        n_valid  = 1'b0;
        n_factor = r_factor;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rem = i_value;
                    n_d   = W'(2);
                    n_sq  = (W + 1)'(4);
                    if (i_value <= W'(1)) begin
                        n_valid  = 1'b1;
                        n_factor = i_value;
                        n_last   = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_sq_over) begin
                    n_valid  = 1'b1;
                    n_factor = r_rem;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_CHECK;
                    if (w_div_rem == '0) begin
                        n_rem    = w_quo;
                        n_valid  = 1'b1;
                        n_factor = r_d;
                        n_last   = 1'b0;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq = r_sq + {r_d, 1'b1};
                        n_d  = r_d + W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_rem    <= n_rem;
        r_d      <= n_d;
        r_sq     <= n_sq;
        r_factor <= n_factor;
        r_last   <= n_last;
    end

    assign o_valid  = r_valid;
    assign o_factor = r_factor;
    assign o_last   = r_last;

    `PF_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `PF_ASSERT_SAME(a_mid_run_busy, i_clk, i_rst_n, r_valid && !r_last, busy)
    `PF_ASSERT_SAME(a_divisor_min, i_clk, i_rst_n, busy, r_d >= W'(2))
    `PF_ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, w_accept, busy || r_valid)

endmodule
